FILE: sv/aesctr_pkg.sv
// ----------------------------------------------------------------------------
// aesctr_pkg
// Shared types, constants and AES round functions for the CTR-mode cipher.
// ----------------------------------------------------------------------------
package aesctr_pkg;

    localparam int NUM_ROUNDS = 14;
    localparam int NUM_WORDS  = 60;
    localparam int NUM_KEYREG = 4;
    localparam logic [7:0] RCON_FIRST = 8'h01;
    localparam logic [7:0] GF_POLY    = 8'h1b;

    // Configuration register indexes
    localparam logic [7:0] REG_KEY_0_7   = 8'd0;
    localparam logic [7:0] REG_KEY_8_15  = 8'd1;
    localparam logic [7:0] REG_KEY_16_23 = 8'd2;
    localparam logic [7:0] REG_KEY_24_31 = 8'd3;

    // One round key per entry, byte 0 in the most significant bits
    typedef logic [NUM_ROUNDS:0][127:0] rk_set_t;

    // Item handed from the front to the back
    typedef struct packed {
        logic [127:0] ctr_block;
        logic [127:0] data;
        logic [15:0]  byte_mask;   // bit 15 is byte 0
        logic [4:0]   count;
    } item_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] gf_double(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // SubBytes + ShiftRows, then MixColumns unless last, then AddRoundKey
    function automatic logic [127:0] aes_round(input logic [127:0] st,
                                               input logic [127:0] rk,
                                               input logic         last);
        logic [7:0]   s [16];
        logic [7:0]   t [16];
        logic [7:0]   a, b, d, e, all;
        logic [127:0] r;
        for (int j = 0; j < 16; j++)
            s[j] = st[127-8*j -: 8];
        for (int c = 0; c < 4; c++)
            for (int q = 0; q < 4; q++)
                t[4*c+q] = SBOX[s[4*((c+q)%4)+q]];
        if (!last)
        begin
            for (int c = 0; c < 4; c++)
            begin
                a = t[4*c]; b = t[4*c+1]; d = t[4*c+2]; e = t[4*c+3];
                all = a ^ b ^ d ^ e;
                t[4*c]   = a ^ all ^ gf_double(a ^ b);
                t[4*c+1] = b ^ all ^ gf_double(b ^ d);
                t[4*c+2] = d ^ all ^ gf_double(d ^ e);
                t[4*c+3] = e ^ all ^ gf_double(e ^ a);
            end
        end
        for (int j = 0; j < 16; j++)
            r[127-8*j -: 8] = t[j];
        return r ^ rk;
    endfunction

endpackage

FILE: sv/aes256_ctr_stream_cipher.sv
// ----------------------------------------------------------------------------
// aes256_ctr_stream_cipher
// AES-256 counter-mode cipher over 16-byte chunks.
// ----------------------------------------------------------------------------
// Takes one chunk per clock and returns one result per clock when pop keeps up
// and no key expansion holds the input. A chunk passes through the input queue
// and the 15 stages of the unrolled cipher (initial key add and one round per
// stage) into the result queue. The 32-entry result queue absorbs stalls on the
// output side. After reset and after every key register write, full stays high
// while the iterative key expansion produces one schedule word a cycle.
// Key writes must happen only while no chunk is in flight.
module aes256_ctr_stream_cipher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        first_chunk,
    input  logic [63:0] block_index,
    input  logic [63:0] chunk_high,
    input  logic [63:0] chunk_low,
    input  logic [4:0]  byte_count,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] result_high,
    output logic [63:0] result_low,
    output logic [4:0]  result_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic                key_busy;
    aesctr_pkg::rk_set_t round_keys;
    logic                q_valid, q_take;
    aesctr_pkg::item_t   q_item;

    assign cfg_ready = 1'b1;

    aesctr_keysched u_keysched
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid & cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .busy       (key_busy),
        .round_keys (round_keys)
    );

    aesctr_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .hold        (key_busy),
        .full        (full),
        .first_chunk (first_chunk),
        .block_index (block_index),
        .chunk_high  (chunk_high),
        .chunk_low   (chunk_low),
        .byte_count  (byte_count),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_take      (q_take)
    );

    aesctr_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_take       (q_take),
        .round_keys   (round_keys),
        .pop          (pop),
        .empty        (empty),
        .result_high  (result_high),
        .result_low   (result_low),
        .result_count (result_count)
    );

    // Checks
    a_full_while_keying: assert property (@(posedge clk) disable iff (!rst_n)
        key_busy |-> full) else $error("input open during key expansion");
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> q_valid) else $error("issue from empty queue");

endmodule

FILE: sv/aesctr_keysched.sv
// ----------------------------------------------------------------------------
// aesctr_keysched
// Key registers and an iterative AES-256 key expansion, one word per cycle.
// ----------------------------------------------------------------------------
module aesctr_keysched
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [7:0]            cfg_index,
    input  logic [63:0]           cfg_data,
    output logic                  busy,
    output aesctr_pkg::rk_set_t   round_keys
);

    logic [63:0]  key_reg [aesctr_pkg::NUM_KEYREG];
    logic         load_reg;
    logic         run_reg;
    logic [5:0]   cnt_reg;
    logic [7:0]   rc_reg;
    logic [31:0]  win_reg [8];
    aesctr_pkg::rk_set_t rk_reg;

    logic [31:0]  t_word;
    logic [31:0]  new_word;
    logic [255:0] key_all;

    assign key_all = {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};

    // Next schedule word from the sliding window
    always_comb
    begin
        t_word = win_reg[7];
        if (cnt_reg[2:0] == 3'd0)
            t_word = aesctr_pkg::sub_word({win_reg[7][23:0], win_reg[7][31:24]})
                     ^ {rc_reg, 24'h0};
        else if (cnt_reg[2:0] == 3'd4)
            t_word = aesctr_pkg::sub_word(win_reg[7]);
        new_word = win_reg[0] ^ t_word;
    end

    // Key registers and expansion sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < aesctr_pkg::NUM_KEYREG; k++)
                key_reg[k] <= '0;
            load_reg <= 1'b1;
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            rc_reg   <= aesctr_pkg::RCON_FIRST;
        end
        else
        begin
            if (cfg_we && (cfg_index == aesctr_pkg::REG_KEY_0_7 ||
                           cfg_index == aesctr_pkg::REG_KEY_8_15 ||
                           cfg_index == aesctr_pkg::REG_KEY_16_23 ||
                           cfg_index == aesctr_pkg::REG_KEY_24_31))
            begin
                key_reg[cfg_index[1:0]] <= cfg_data;
                load_reg <= 1'b1;
            end
            else if (load_reg)
            begin
                load_reg <= 1'b0;
                run_reg  <= 1'b1;
                cnt_reg  <= 6'd8;
                rc_reg   <= aesctr_pkg::RCON_FIRST;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg[2:0] == 3'd0)
                    rc_reg <= aesctr_pkg::gf_double(rc_reg);
                if (cnt_reg == 6'(aesctr_pkg::NUM_WORDS - 1))
                    run_reg <= 1'b0;
            end
        end
    end

    // Window and round key storage
    always_ff @(posedge clk)
    begin
        if (load_reg)
        begin
            for (int k = 0; k < 8; k++)
                win_reg[k] <= key_all[255-32*k -: 32];
            rk_reg[0] <= key_all[255:128];
            rk_reg[1] <= key_all[127:0];
        end
        else if (run_reg)
        begin
            for (int k = 0; k < 7; k++)
                win_reg[k] <= win_reg[k+1];
            win_reg[7] <= new_word;
            rk_reg[cnt_reg[5:2]][127-32*cnt_reg[1:0] -: 32] <= new_word;
        end
    end

    assign busy       = load_reg | run_reg;
    assign round_keys = rk_reg;

endmodule

FILE: sv/aesctr_front.sv
// ----------------------------------------------------------------------------
// aesctr_front
// Accepts chunks, tracks index and counter, builds counter blocks and byte
// masks, and holds them in a two-entry queue for the cipher pipeline.
// ----------------------------------------------------------------------------
module aesctr_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                hold,
    output logic                full,
    input  logic                first_chunk,
    input  logic [63:0]         block_index,
    input  logic [63:0]         chunk_high,
    input  logic [63:0]         chunk_low,
    input  logic [4:0]          byte_count,
    output logic                q_valid,
    output aesctr_pkg::item_t   q_item,
    input  logic                q_take
);

    logic [63:0]       index_reg, index_next;
    logic [63:0]       ctr_reg, ctr_next;
    logic [1:0]        qcnt_reg;
    logic              wr_ptr_reg, rd_ptr_reg;
    aesctr_pkg::item_t q_reg [2];
    aesctr_pkg::item_t new_item;
    logic [63:0]       ctr_use;
    logic              accept;

    assign full   = (qcnt_reg == 2'd2) | hold;
    assign accept = push & ~full;

    // Counter block and byte mask for the incoming chunk
    always_comb
    begin
        index_next = first_chunk ? block_index : index_reg;
        ctr_use    = first_chunk ? 64'd0 : ctr_reg;
        ctr_next   = ctr_use + 64'd1;
        for (int i = 0; i < 8; i++)
            new_item.ctr_block[127-8*i -: 8] = index_next[8*i +: 8];
        new_item.ctr_block[63:0] = ctr_use;
        new_item.data = {chunk_high, chunk_low};
        for (int i = 0; i < 16; i++)
            new_item.byte_mask[15-i] = 5'(i) < byte_count;
        new_item.count = byte_count;
    end

    // Message state and queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg  <= '0;
            ctr_reg    <= '0;
            qcnt_reg   <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                index_reg  <= index_next;
                ctr_reg    <= ctr_next;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_take)
                rd_ptr_reg <= ~rd_ptr_reg;
            qcnt_reg <= qcnt_reg + {1'b0, accept} - {1'b0, q_take};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            q_reg[wr_ptr_reg] <= new_item;
    end

    assign q_valid = qcnt_reg != 2'd0;
    assign q_item  = q_reg[rd_ptr_reg];

endmodule

FILE: sv/aesctr_back.sv
// ----------------------------------------------------------------------------
// aesctr_back
// Fifteen-stage unrolled AES-256 pipeline with credit flow control into a
// 32-entry result queue.
// ----------------------------------------------------------------------------
module aesctr_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  aesctr_pkg::item_t   q_item,
    output logic                q_take,
    input  aesctr_pkg::rk_set_t round_keys,
    input  logic                pop,
    output logic                empty,
    output logic [63:0]         result_high,
    output logic [63:0]         result_low,
    output logic [4:0]          result_count
);

    localparam int NST = aesctr_pkg::NUM_ROUNDS + 1;
    localparam int QD  = 32;

    logic [NST-1:0] v_reg;
    logic [127:0]   st_reg   [NST];
    logic [127:0]   dat_reg  [NST];
    logic [15:0]    msk_reg  [NST];
    logic [4:0]     cnt_reg  [NST];

    logic [5:0]     credit_reg;   // items in pipe plus queue
    logic [5:0]     fcnt_reg;
    logic [4:0]     wp_reg, rp_reg;
    logic [132:0]   fifo_mem [QD];
    logic [127:0]   ks_x;
    logic           do_pop;

    assign q_take = q_valid && (credit_reg < 6'(QD));
    assign do_pop = pop && !empty;

    // Valid bits and flow control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg      <= '0;
            credit_reg <= '0;
            fcnt_reg   <= '0;
            wp_reg     <= '0;
            rp_reg     <= '0;
        end
        else
        begin
            v_reg      <= {v_reg[NST-2:0], q_take};
            credit_reg <= credit_reg + {5'd0, q_take} - {5'd0, do_pop};
            fcnt_reg   <= fcnt_reg + {5'd0, v_reg[NST-1]} - {5'd0, do_pop};
            if (v_reg[NST-1])
                wp_reg <= wp_reg + 5'd1;
            if (do_pop)
                rp_reg <= rp_reg + 5'd1;
        end
    end

    // Cipher stages: initial key add, 13 full rounds, final round
    always_ff @(posedge clk)
    begin
        st_reg[0]  <= q_item.ctr_block ^ round_keys[0];
        dat_reg[0] <= q_item.data;
        msk_reg[0] <= q_item.byte_mask;
        cnt_reg[0] <= q_item.count;
        for (int k = 1; k < NST; k++)
        begin
            st_reg[k]  <= aesctr_pkg::aes_round(st_reg[k-1], round_keys[k],
                                                k == NST - 1);
            dat_reg[k] <= dat_reg[k-1];
            msk_reg[k] <= msk_reg[k-1];
            cnt_reg[k] <= cnt_reg[k-1];
        end
    end

    // Keystream XOR with invalid bytes forced to zero
    always_comb
    begin
        for (int j = 0; j < 16; j++)
            ks_x[127-8*j -: 8] = msk_reg[NST-1][15-j]
                                 ? (st_reg[NST-1][127-8*j -: 8] ^ dat_reg[NST-1][127-8*j -: 8])
                                 : 8'h00;
    end

    always_ff @(posedge clk)
    begin
        if (v_reg[NST-1])
            fifo_mem[wp_reg] <= {ks_x, cnt_reg[NST-1]};
    end

    assign empty        = fcnt_reg == 6'd0;
    assign result_high  = fifo_mem[rp_reg][132:69];
    assign result_low   = fifo_mem[rp_reg][68:5];
    assign result_count = fifo_mem[rp_reg][4:0];

    // Checks
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= 6'(QD)) else $error("credit overflow");
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg <= credit_reg) else $error("queue count exceeds credit");
    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NST-1] |-> (fcnt_reg < 6'(QD) || do_pop)) else $error("queue overrun");

endmodule
